### sv/i2c_eeprom_word_access_sequencer_core_defines.svh
// assertion macros for the eeprom sequencer rtl
`ifndef I2C_EEPROM_WORD_ACCESS_SEQUENCER_CORE_DEFINES_SVH
`define I2C_EEPROM_WORD_ACCESS_SEQUENCER_CORE_DEFINES_SVH

// property must hold at every rising clock edge out of reset
`define I2CW_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// condition must never be seen out of reset
`define I2CW_NEVER(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### sv/i2cw_pkg.sv
// types and constants of the eeprom word access sequencer
`timescale 1ns / 1ps
`default_nettype none

package i2cw_pkg;

  localparam int BytesPerWord = 4;
  localparam int MaxResults   = 4;
  localparam int WordBytes    = 4;
  localparam int CntW         = $clog2(MaxResults + 1);

  localparam logic [7:0]  DeviceIdReset     = 8'ha0;
  localparam logic [2:0]  AddressBytesReset = 3'd2;
  localparam logic [31:0] BaseAddressReset  = 32'h0;
  localparam logic [7:0]  ReadFillByte      = 8'hff;

  typedef enum logic [1:0] {
    OP_PROBE = 2'd0,
    OP_READ  = 2'd1,
    OP_WRITE = 2'd2,
    OP_RESP  = 2'd3
  } opcode_e;

  typedef enum logic [1:0] {
    CMD_START  = 2'd0,
    CMD_XFER   = 2'd1,
    CMD_STOP   = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    PH_IDLE   = 3'd0,
    PH_PROBE  = 3'd1,
    PH_DEVID  = 3'd2,
    PH_ADDR   = 3'd3,
    PH_RDID   = 3'd4,
    PH_RDDATA = 3'd5,
    PH_WRDATA = 3'd6,
    PH_POLL   = 3'd7
  } phase_e;

  typedef enum logic [1:0] {
    KIND_PROBE = 2'd0,
    KIND_READ  = 2'd1,
    KIND_WRITE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    REG_DEVICE_ID     = 2'd0,
    REG_ADDRESS_BYTES = 2'd1,
    REG_BASE_ADDRESS  = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [7:0]  device_id;
    logic [2:0]  address_bytes;
    logic [31:0] base_address;
  } cfg_t;

  typedef struct packed {
    cmd_e        cmd;
    logic [7:0]  tx_byte;
    logic        error_flag;
    logic [31:0] read_word;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

### sv/i2c_eeprom_word_access_sequencer_core.sv
// top level of the eeprom word access sequencer: config registers and result queue
//
//   channel   direction  handshake               payload
//   s_axis    in         tvalid/tready           tuser opcode, tdata request/response
//   m_axis    out        tvalid/tready/tlast     tuser bus command, tdata byte/flag/word
//   cfg       in         cfg_we_i                cfg_addr_i index, cfg_wdata_i value
//
// a transaction is worked out when it is accepted and its 0 to 3 results land in a 4-entry queue
// the queue drains one result per cycle while m_axis_tready is high
// the next input is taken in the cycle the last queued result leaves
// an input that yields no result leaves the queue empty
// reset clears the queue and the sequencer state, registers return to their defaults
`timescale 1ns / 1ps
`default_nettype none
`include "i2c_eeprom_word_access_sequencer_core_defines.svh"

module i2c_eeprom_word_access_sequencer_core import i2cw_pkg::*; #(
  parameter int BYTES_PER_WORD = BytesPerWord
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        cfg_we_i,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [31:0] cfg_wdata_i,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // write_word [31:0], bus_ack [32], bus_rx_byte [40:33], zero fill
  input  wire logic [47:0] s_axis_tdata,
  // opcode [1:0]
  input  wire logic [1:0]  s_axis_tuser,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // tx_byte [7:0], error_flag [8], read_word [40:9], zero fill
  output logic [47:0]      m_axis_tdata,
  // bus_command [1:0]
  output logic [1:0]       m_axis_tuser,
  output logic             m_axis_tlast
);

  cfg_t cfg_q;

  result_t [MaxResults-1:0] res;
  logic    [CntW-1:0]       res_cnt;
  result_t [MaxResults-1:0] buf_q, buf_d;
  logic    [CntW-1:0]       cnt_q, cnt_d;
  logic                     accept;
  logic                     take;
  result_t                  head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_id     <= DeviceIdReset;
      cfg_q.address_bytes <= AddressBytesReset;
      cfg_q.base_address  <= BaseAddressReset;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        REG_DEVICE_ID:     cfg_q.device_id     <= cfg_wdata_i[7:0];
        REG_ADDRESS_BYTES: cfg_q.address_bytes <= cfg_wdata_i[2:0];
        REG_BASE_ADDRESS:  cfg_q.base_address  <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  assign take          = m_axis_tvalid && m_axis_tready;
  assign s_axis_tready = (cnt_q == '0) || ((cnt_q == CntW'(1)) && m_axis_tready);
  assign accept        = s_axis_tvalid && s_axis_tready;

  i2cw_seq #(
    .BYTES_PER_WORD(BYTES_PER_WORD)
  ) u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .accept_i     (accept),
    .opcode_i     (opcode_e'(s_axis_tuser)),
    .write_word_i (s_axis_tdata[31:0]),
    .bus_ack_i    (s_axis_tdata[32]),
    .bus_rx_byte_i(s_axis_tdata[40:33]),
    .res_o        (res),
    .res_cnt_o    (res_cnt)
  );

  // result queue, head always at entry zero
  always_comb begin
    buf_d = buf_q;
    cnt_d = cnt_q;
    if (accept) begin
      buf_d = res;
      cnt_d = res_cnt;
    end else if (take) begin
      for (int i = 0; i < MaxResults - 1; i++) begin
        buf_d[i] = buf_q[i+1];
      end
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    buf_q <= buf_d;
  end

  assign head          = buf_q[0];
  assign m_axis_tvalid = cnt_q != '0;
  assign m_axis_tuser  = head.cmd;
  assign m_axis_tlast  = head.last;
  assign m_axis_tdata  = {7'b0, head.read_word, head.error_flag, head.tx_byte};

  `I2CW_NEVER(a_cnt_range, clk_i, rst_ni, cnt_q > CntW'(MaxResults), "queue count overflow")
  `I2CW_ASSERT(a_last_is_tail, clk_i, rst_ni, m_axis_tvalid |-> (m_axis_tlast == (cnt_q == CntW'(1))), "tlast not on final queued result")
  `I2CW_ASSERT(a_results_show, clk_i, rst_ni, (accept && res_cnt != '0) |=> m_axis_tvalid, "results of a transaction not presented")
  `I2CW_ASSERT(a_no_overwrite, clk_i, rst_ni, accept |-> (cnt_q == '0 || (cnt_q == CntW'(1) && take)), "pending results overwritten")

endmodule

`default_nettype wire

### sv/i2cw_seq.sv
// access sequencer state and per-transaction result generation
`timescale 1ns / 1ps
`default_nettype none

module i2cw_seq import i2cw_pkg::*; #(
  parameter int BYTES_PER_WORD = BytesPerWord
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire cfg_t                         cfg_i,
  input  wire logic                         accept_i,
  input  wire opcode_e                      opcode_i,
  input  wire logic [31:0]                  write_word_i,
  input  wire logic                         bus_ack_i,
  input  wire logic [7:0]                   bus_rx_byte_i,
  output result_t [MaxResults-1:0]          res_o,
  output logic    [CntW-1:0]                res_cnt_o
);

  localparam int IdxW = (BYTES_PER_WORD > 1) ? $clog2(BYTES_PER_WORD) : 1;

  logic [31:0]     byte_address_q, byte_address_d;
  phase_e          phase_q, phase_d;
  kind_e           kind_q, kind_d;
  logic [IdxW-1:0] byte_index_q, byte_index_d;
  logic [1:0]      addr_cnt_q, addr_cnt_d;
  logic            sticky_q, sticky_d;
  logic [31:0]     data_word_q, data_word_d;
  logic            addr_nack_q, addr_nack_d;

  result_t [MaxResults-1:0] res;
  logic [CntW-1:0] n;
  logic [CntW-1:0] n_last;
  logic            do_next;
  logic            do_begin;
  logic            in_word;
  logic            last_byte;
  logic [1:0]      bsel;
  logic [1:0]      addr_top;
  logic            nack_now;

  function automatic result_t mk(cmd_e c, logic [7:0] tx, logic err, logic [31:0] w);
    result_t r;
    r.cmd        = c;
    r.tx_byte    = tx;
    r.error_flag = err;
    r.read_word  = w;
    r.last       = 1'b0;
    return r;
  endfunction

  // out-of-range address byte counts clamp to one or four
  always_comb begin
    case (cfg_i.address_bytes)
      3'd0, 3'd1: addr_top = 2'd0;
      3'd2:       addr_top = 2'd1;
      3'd3:       addr_top = 2'd2;
      default:    addr_top = 2'd3;
    endcase
  end

  assign bsel      = 2'(byte_index_q);
  assign in_word   = 32'(byte_index_q) < 32'(WordBytes);
  assign last_byte = byte_index_q == IdxW'(BYTES_PER_WORD - 1);
  assign nack_now  = addr_nack_q | ~bus_ack_i;

  always_comb begin
    byte_address_d = byte_address_q;
    phase_d        = phase_q;
    kind_d         = kind_q;
    byte_index_d   = byte_index_q;
    addr_cnt_d     = addr_cnt_q;
    sticky_d       = sticky_q;
    data_word_d    = data_word_q;
    addr_nack_d    = addr_nack_q;
    res            = '0;
    n              = '0;
    n_last         = '0;
    do_next        = 1'b0;
    do_begin       = 1'b0;

    if (accept_i) begin
      if (opcode_i != OP_RESP) begin
        if (phase_q == PH_IDLE) begin
          sticky_d     = 1'b0;
          byte_index_d = '0;
          if (opcode_i == OP_PROBE) begin
            kind_d         = KIND_PROBE;
            byte_address_d = cfg_i.base_address;
            res[n[1:0]]    = mk(CMD_START, 8'h00, 1'b0, 32'h0);
            n              = n + 1'b1;
            res[n[1:0]]    = mk(CMD_XFER, cfg_i.device_id, 1'b0, 32'h0);
            n              = n + 1'b1;
            phase_d        = PH_PROBE;
          end else begin
            kind_d      = (opcode_i == OP_READ) ? KIND_READ : KIND_WRITE;
            data_word_d = (opcode_i == OP_READ) ? 32'h0 : write_word_i;
            do_begin    = 1'b1;
          end
        end
      end else begin
        case (phase_q)
          PH_IDLE: begin
          end
          PH_PROBE: begin
            res[n[1:0]] = mk(CMD_STOP, 8'h00, 1'b0, 32'h0);
            n           = n + 1'b1;
            res[n[1:0]] = mk(CMD_REPORT, 8'h00, ~bus_ack_i, 32'h0);
            n           = n + 1'b1;
            phase_d     = PH_IDLE;
          end
          PH_DEVID: begin
            if (!bus_ack_i) begin
              sticky_d = 1'b1;
              do_next  = 1'b1;
            end else begin
              addr_cnt_d  = addr_top;
              res[n[1:0]] = mk(CMD_XFER, byte_address_q[8*addr_top +: 8], 1'b0, 32'h0);
              n           = n + 1'b1;
              phase_d     = PH_ADDR;
            end
          end
          PH_ADDR: begin
            addr_nack_d = nack_now;
            if (addr_cnt_q != 2'd0) begin
              addr_cnt_d  = addr_cnt_q - 2'd1;
              res[n[1:0]] = mk(CMD_XFER, byte_address_q[8*addr_cnt_d +: 8], 1'b0, 32'h0);
              n           = n + 1'b1;
            end else if (nack_now) begin
              sticky_d = 1'b1;
              do_next  = 1'b1;
            end else if (kind_q == KIND_READ) begin
              res[n[1:0]] = mk(CMD_START, 8'h00, 1'b0, 32'h0);
              n           = n + 1'b1;
              res[n[1:0]] = mk(CMD_XFER, cfg_i.device_id | 8'h01, 1'b0, 32'h0);
              n           = n + 1'b1;
              phase_d     = PH_RDID;
            end else begin
              res[n[1:0]] = mk(CMD_XFER, in_word ? data_word_q[8*bsel +: 8] : 8'h00,
                               1'b0, 32'h0);
              n           = n + 1'b1;
              phase_d     = PH_WRDATA;
            end
          end
          PH_RDID: begin
            if (!bus_ack_i) begin
              sticky_d = 1'b1;
              do_next  = 1'b1;
            end else begin
              res[n[1:0]] = mk(CMD_XFER, ReadFillByte, 1'b0, 32'h0);
              n           = n + 1'b1;
              phase_d     = PH_RDDATA;
            end
          end
          PH_RDDATA: begin
            // ack of the data byte is ignored
            if (in_word) begin
              data_word_d[8*bsel +: 8] = data_word_q[8*bsel +: 8] | bus_rx_byte_i;
            end
            res[n[1:0]] = mk(CMD_STOP, 8'h00, 1'b0, 32'h0);
            n           = n + 1'b1;
            do_next     = 1'b1;
          end
          PH_WRDATA: begin
            if (!bus_ack_i) begin
              sticky_d = 1'b1;
              do_next  = 1'b1;
            end else begin
              res[n[1:0]] = mk(CMD_STOP, 8'h00, 1'b0, 32'h0);
              n           = n + 1'b1;
              res[n[1:0]] = mk(CMD_START, 8'h00, 1'b0, 32'h0);
              n           = n + 1'b1;
              res[n[1:0]] = mk(CMD_XFER, cfg_i.device_id, 1'b0, 32'h0);
              n           = n + 1'b1;
              phase_d     = PH_POLL;
            end
          end
          PH_POLL: begin
            res[n[1:0]] = mk(CMD_STOP, 8'h00, 1'b0, 32'h0);
            n           = n + 1'b1;
            if (bus_ack_i) begin
              do_next = 1'b1;
            end else begin
              res[n[1:0]] = mk(CMD_START, 8'h00, 1'b0, 32'h0);
              n           = n + 1'b1;
              res[n[1:0]] = mk(CMD_XFER, cfg_i.device_id, 1'b0, 32'h0);
              n           = n + 1'b1;
            end
          end
          default: begin
            phase_d = PH_IDLE;
          end
        endcase
      end

      // advance to the next byte, or finish the word with a report
      if (do_next) begin
        byte_address_d = byte_address_q + 32'd1;
        if (last_byte) begin
          res[n[1:0]] = mk(CMD_REPORT, 8'h00, sticky_d,
                           (kind_q == KIND_READ) ? data_word_d : 32'h0);
          n           = n + 1'b1;
          phase_d     = PH_IDLE;
        end else begin
          byte_index_d = byte_index_q + 1'b1;
          do_begin     = 1'b1;
        end
      end

      if (do_begin) begin
        res[n[1:0]] = mk(CMD_START, 8'h00, 1'b0, 32'h0);
        n           = n + 1'b1;
        res[n[1:0]] = mk(CMD_XFER, cfg_i.device_id, 1'b0, 32'h0);
        n           = n + 1'b1;
        addr_nack_d = 1'b0;
        phase_d     = PH_DEVID;
      end

      if (n != '0) begin
        n_last                  = n - 1'b1;
        res[n_last[1:0]].last   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_address_q <= '0;
      phase_q        <= PH_IDLE;
      kind_q         <= KIND_PROBE;
      byte_index_q   <= '0;
      addr_cnt_q     <= '0;
      sticky_q       <= 1'b0;
      data_word_q    <= '0;
      addr_nack_q    <= 1'b0;
    end else begin
      byte_address_q <= byte_address_d;
      phase_q        <= phase_d;
      kind_q         <= kind_d;
      byte_index_q   <= byte_index_d;
      addr_cnt_q     <= addr_cnt_d;
      sticky_q       <= sticky_d;
      data_word_q    <= data_word_d;
      addr_nack_q    <= addr_nack_d;
    end
  end

  assign res_o     = res;
  assign res_cnt_o = n;

endmodule

`default_nettype wire
